// File: hdl/crng_pkg.sv
package crng_pkg;

  localparam int WORD_W       = 32;
  localparam int ENT_W        = 64;
  localparam int LCG_W        = 17;
  localparam int WARMUP_STEPS = 6;
  localparam int WARM_W       = $clog2(WARMUP_STEPS + 2);

  localparam logic [LCG_W-1:0] LCG_MULT = LCG_W'(69069);

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MIN_A = WORD_W'(2);
  localparam word_t MIN_B = WORD_W'(8);
  localparam word_t MIN_C = WORD_W'(16);

  localparam word_t MASK_A = WORD_W'(32'hFFFF_FFFE);
  localparam word_t MASK_B = WORD_W'(32'hFFFF_FFF8);
  localparam word_t MASK_C = WORD_W'(32'hFFFF_FFF0);

  typedef enum logic [2:0] {
    ST_LCG_A,
    ST_LCG_B,
    ST_LCG_C,
    ST_WARM,
    ST_ACK,
    ST_IDLE,
    ST_DRAW
  } state_t;

  typedef enum logic [2:0] {
    WOP_HOLD,
    WOP_STEP,
    WOP_ENTROPY,
    WOP_LCG_A,
    WOP_LCG_B,
    WOP_LCG_C
  } word_op_t;

  typedef struct packed {
    word_op_t word_op;
    logic     seed_one;
    logic     out_load;
    logic     out_ack;
  } dp_cmd_t;

  typedef struct packed {
    logic step_nz;
    logic out_free;
    logic kind;
    logic seed_zero;
  } dp_stat_t;

  function automatic word_t step_a(input word_t s);
    return ((s & MASK_A) << 12) ^ (((s << 13) ^ s) >> 19);
  endfunction

  function automatic word_t step_b(input word_t s);
    return ((s & MASK_B) << 4) ^ (((s << 2) ^ s) >> 25);
  endfunction

  function automatic word_t step_c(input word_t s);
    return ((s & MASK_C) << 17) ^ (((s << 3) ^ s) >> 11);
  endfunction

  function automatic word_t lift(input word_t w, input word_t floor_val);
    return (w < floor_val) ? w + floor_val : w;
  endfunction

endpackage

// File: hdl/crng_if.sv
interface crng_in_if;
  import crng_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  word_t             seed;
  logic [ENT_W-1:0]  entropy_low;
  logic [ENT_W-1:0]  entropy_high;

  modport source (output valid, kind, seed, entropy_low, entropy_high, input ready);
  modport sink   (input valid, kind, seed, entropy_low, entropy_high, output ready);
endinterface

interface crng_out_if;
  import crng_pkg::*;

  logic  valid;
  logic  ready;
  word_t number;
  logic  reseeded;

  modport source (output valid, number, reseeded, input ready);
  modport sink   (input valid, number, reseeded, output ready);
endinterface

// File: hdl/crng_dp.sv
module crng_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          kind,
  input  crng_pkg::word_t               seed,
  input  logic [crng_pkg::ENT_W-1:0]    entropy_low,
  input  logic [crng_pkg::ENT_W-1:0]    entropy_high,
  output logic                          out_valid,
  input  logic                          out_ready,
  output crng_pkg::word_t               out_number,
  output logic                          out_reseeded,
  input  crng_pkg::dp_cmd_t             cmd,
  output crng_pkg::dp_stat_t            stat
);
  import crng_pkg::*;

  word_t word_a;
  word_t word_b;
  word_t word_c;
  word_t na;
  word_t nb;
  word_t nc;
  word_t mix;
  word_t mul_op;
  word_t ent_sum;
  logic [WORD_W+LCG_W-1:0] product;
  word_t mul_res;

  assign na  = step_a(word_a);
  assign nb  = step_b(word_b);
  assign nc  = step_c(word_c);
  assign mix = na ^ nb ^ nc;

  always_comb begin
    unique case (cmd.word_op)
      WOP_LCG_A: mul_op = cmd.seed_one ? WORD_W'(1) : seed;
      WOP_LCG_B: mul_op = word_a;
      default:   mul_op = word_b;
    endcase
  end

  assign product = mul_op * LCG_MULT;
  assign mul_res = product[WORD_W-1:0];
  assign ent_sum = entropy_high[WORD_W-1:0] + entropy_high[2*WORD_W-1:WORD_W];

  always_ff @(posedge clk) begin
    case (cmd.word_op)
      WOP_STEP: begin
        word_a <= na;
        word_b <= nb;
        word_c <= nc;
      end
      WOP_ENTROPY: begin
        word_a <= lift(entropy_low[WORD_W-1:0], MIN_A);
        word_b <= lift(entropy_low[2*WORD_W-1:WORD_W], MIN_B);
        word_c <= lift(ent_sum, MIN_C);
      end
      WOP_LCG_A: word_a <= lift(mul_res, MIN_A);
      WOP_LCG_B: word_b <= lift(mul_res, MIN_B);
      WOP_LCG_C: word_c <= lift(mul_res, MIN_C);
      default: ;
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_number   <= cmd.out_ack ? '0 : mix;
      out_reseeded <= cmd.out_ack;
    end
  end

  assign stat.step_nz   = |mix;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.kind      = kind;
  assign stat.seed_zero = (seed == '0);

endmodule

// File: hdl/crng_ctrl.sv
module crng_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output crng_pkg::dp_cmd_t  cmd,
  input  crng_pkg::dp_stat_t stat
);
  import crng_pkg::*;

  localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(WARMUP_STEPS - 1);
  localparam logic              HAS_WARM  = (WARMUP_STEPS != 0);

  state_t            state;
  state_t            state_next;
  logic              boot;
  logic              boot_next;
  logic [WARM_W-1:0] cnt;
  logic [WARM_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LCG_A;
      boot  <= 1'b1;
      cnt   <= '0;
    end else begin
      state <= state_next;
      boot  <= boot_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    boot_next    = boot;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd.word_op  = WOP_HOLD;
    cmd.seed_one = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_ack  = 1'b0;
    unique case (state)
      ST_LCG_A: begin
        cmd.word_op  = WOP_LCG_A;
        cmd.seed_one = 1'b1;
        state_next   = ST_LCG_B;
      end
      ST_LCG_B: begin
        cmd.word_op = WOP_LCG_B;
        state_next  = ST_LCG_C;
      end
      ST_LCG_C: begin
        cmd.word_op = WOP_LCG_C;
        cnt_next    = '0;
        if (HAS_WARM) begin
          state_next = ST_WARM;
        end else begin
          state_next = boot ? ST_IDLE : ST_ACK;
          boot_next  = 1'b0;
        end
      end
      ST_WARM: begin
        cmd.word_op = WOP_STEP;
        if (stat.step_nz) begin
          if (cnt == WARM_LAST) begin
            state_next = boot ? ST_IDLE : ST_ACK;
            boot_next  = 1'b0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_ACK: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ack  = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (stat.kind == KIND_RESEED) begin
            cnt_next = '0;
            if (stat.seed_zero) begin
              cmd.word_op = WOP_ENTROPY;
              state_next  = HAS_WARM ? ST_WARM : ST_ACK;
            end else begin
              cmd.word_op = WOP_LCG_A;
              state_next  = ST_LCG_B;
            end
          end else begin
            cmd.word_op = WOP_STEP;
            if (stat.step_nz) begin
              cmd.out_load = 1'b1;
            end else begin
              state_next = ST_DRAW;
            end
          end
        end
      end
      ST_DRAW: begin
        if (stat.out_free) begin
          cmd.word_op = WOP_STEP;
          if (stat.step_nz) begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_LCG_A;
      end
    endcase
  end

endmodule

// File: hdl/combined_tausworthe_rng.sv
// Combined three-word Tausworthe random number generator.
// request channel: one beat per item. kind = 0 asks for a draw, kind = 1
// reseeds from seed (nonzero: LCG chain) or from the entropy words (seed 0).
// result channel: exactly one beat per request, in order. A draw returns a
// nonzero 0.32 fraction in number with reseeded low; a reseed returns
// number = 0 with reseeded high once the new state is warmed up.
// Throughput: a draw normally takes one Tausworthe step, plus one more for
// each step whose combined XOR is zero; draws stream at one per cycle while
// the result channel is not stalled.
// A reseed runs the LCG chain (steps A, B, C) through the shared 32x17
// multiplier, or the entropy load, starting in the accept cycle.
// Warm-up steps follow until WARMUP_STEPS of them had a nonzero combined
// XOR, then the acknowledgement beat is loaded once the output register is
// free. request.ready stays low from the cycle after the accept until the
// acknowledgement is loaded.
// Reset: the block runs a seed-one reseed with warm-up, with request.ready
// low and no result beat.
// A stalled result holds in the output register; a new request is taken in
// the same cycle that the waiting beat is taken, otherwise ready stays low.
module combined_tausworthe_rng (
  input logic        clk,
  input logic        rst,
  crng_in_if.sink    request,
  crng_out_if.source result
);
  import crng_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign request.ready = in_ready;

  crng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  crng_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .kind         (request.kind),
    .seed         (request.seed),
    .entropy_low  (request.entropy_low),
    .entropy_high (request.entropy_high),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_number   (result.number),
    .out_reseeded (result.reseeded),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// File: hdl/crng_check.sv
module crng_check (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_kind,
  input logic            out_valid,
  input logic            out_ready,
  input crng_pkg::word_t out_number,
  input logic            out_reseeded
);
  import crng_pkg::*;

  // reset runs a boot reseed first
  a_boot_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("request ready straight after reset");

  a_reseed_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_kind == KIND_RESEED) |=> !in_ready)
    else $error("request ready in the cycle after a reseed");

  a_draw_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reseeded) |-> (out_number != '0))
    else $error("zero draw result");

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reseeded) |-> (out_number == '0))
    else $error("reseed acknowledgement carries a number");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_number)))
    else $error("stalled result beat dropped or changed");

endmodule

bind combined_tausworthe_rng crng_check u_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (request.valid),
  .in_ready     (request.ready),
  .in_kind      (request.kind),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_number   (result.number),
  .out_reseeded (result.reseeded)
);
